// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on aclk
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define ASSERT_AT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ----- rtl/rcppm_pkg.sv -----
// ----------------------------------------------------------------------------
// rcppm_pkg
// shared types and constants of the rc ppm pulse train generator
// ----------------------------------------------------------------------------
package rcppm_pkg;

    // number of channels in one frame
    localparam int NUM_CH = 8;
    localparam int CH_AW  = (NUM_CH > 1) ? $clog2(NUM_CH) : 1;
    // channel pointer runs 0..NUM_CH
    localparam int PTR_W  = $clog2(NUM_CH + 1);

    localparam int TIME_W = 15;
    localparam int CH_W   = 16;
    localparam int IDX_W  = 4;

    localparam logic [TIME_W-1:0] FRAME_LEN_RST = 15'd22500;
    localparam logic [TIME_W-1:0] SYNC_RST      = 15'd300;
    localparam logic [TIME_W-1:0] CH_MIN_RST    = 15'd1000;
    localparam logic [TIME_W-1:0] CH_MAX_RST    = 15'd2000;
    // midpoint of the default limits
    localparam logic [CH_W-1:0]   CH_RESET      = 16'((1000 + 2000) / 2);
    localparam logic [CH_W-1:0]   COMPARE_RST   = 16'd255;

    typedef enum logic {
        FUNC_TICK  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    typedef enum logic [2:0] {
        REG_FRAME_LEN = 3'd0,
        REG_SYNC      = 3'd1,
        REG_CH_MIN    = 3'd2,
        REG_CH_MAX    = 3'd3,
        REG_INVERT    = 3'd4
    } reg_idx_t;

endpackage

// ----- rtl/rcppm_ram.sv -----
// ----------------------------------------------------------------------------
// rcppm_ram
// generic single-write, single-read ram with registered read (read-first)
// ----------------------------------------------------------------------------
module rcppm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/rc_ppm_pulse_train_generator_core.sv -----
// ----------------------------------------------------------------------------
// rc_ppm_pulse_train_generator_core
// rc ppm pulse train generator counting half-microsecond ticks
// ----------------------------------------------------------------------------
//
// channel   direction  beat contents
// s_*       in         tuser: func, tdata: channel_index, channel_value_us
// m_*       out        tdata: ppm_level, tuser: frame_start
// apb       in/out     five config registers at byte address 4*i
//
// one beat per clock, in and out, while the output is not stalled; every input beat gives one output beat
// a beat's result sits in the output register the cycle after acceptance
// the output register drains while the next beat is taken; only a stall
// with a full output register holds s_tready low
// reset (aresetn low, synchronous) restores registers and channel defaults
// at once; there is no clearing pass, per-channel valid bits cover the ram
//
module rc_ppm_pulse_train_generator_core (
    input  logic                  aclk,
    input  logic                  aresetn,

    // apb config port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [4:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,

    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [3:0] channel_index, [19:4] channel_value_us
    input  rcppm_pkg::func_t      s_tuser,   // [0] func

    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,   // [0] ppm_level
    output logic                  m_tuser    // [0] frame_start
);

    import rcppm_pkg::*;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(NUM_CH);
    localparam logic [IDX_W:0]   IDX_LIM  = (IDX_W + 1)'(NUM_CH);

    // config registers
    logic [TIME_W-1:0] frame_len_reg;
    logic [TIME_W-1:0] sync_reg;
    logic [TIME_W-1:0] ch_min_reg;
    logic [TIME_W-1:0] ch_max_reg;
    logic              invert_reg;

    // timing state
    logic              goes_low_reg,  goes_low_next;
    logic [PTR_W-1:0]  ptr_reg,       ptr_next;
    logic [CH_W-1:0]   acc_reg,       acc_next;
    logic [CH_W-1:0]   compare_reg,   compare_next;
    logic [CH_W-1:0]   tick_cnt_reg,  tick_cnt_next;
    logic              pin_reg,       pin_next;
    logic              fs_next;

    // channel store: ram plus valid bits and write forwarding
    logic [NUM_CH-1:0] valid_reg;
    logic              rd_valid_reg;
    logic              fwd_hit_reg;
    logic [CH_W-1:0]   fwd_data_reg;
    logic [CH_W-1:0]   ram_rdata;
    logic [CH_AW-1:0]  rd_addr;
    logic [CH_AW-1:0]  wr_addr;
    logic              wr_en;
    logic [CH_W-1:0]   wr_val;
    logic [CH_W-1:0]   cur_ch;

    // output register
    logic              m_valid_reg;
    logic              ppm_reg;
    logic              fs_reg;

    logic              in_acc;
    logic              is_tick;
    logic              cfg_wr;
    reg_idx_t          cfg_idx;

    // ------------------------------------------------------------------
    // apb config
    // ------------------------------------------------------------------
    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_len_reg <= FRAME_LEN_RST;
            sync_reg      <= SYNC_RST;
            ch_min_reg    <= CH_MIN_RST;
            ch_max_reg    <= CH_MAX_RST;
            invert_reg    <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_FRAME_LEN: frame_len_reg <= pwdata[TIME_W-1:0];
                REG_SYNC:      sync_reg      <= pwdata[TIME_W-1:0];
                REG_CH_MIN:    ch_min_reg    <= pwdata[TIME_W-1:0];
                REG_CH_MAX:    ch_max_reg    <= pwdata[TIME_W-1:0];
                REG_INVERT:    invert_reg    <= pwdata[0];
                default: ;  // addresses past the register list are ignored
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_FRAME_LEN: prdata = {17'd0, frame_len_reg};
            REG_SYNC:      prdata = {17'd0, sync_reg};
            REG_CH_MIN:    prdata = {17'd0, ch_min_reg};
            REG_CH_MAX:    prdata = {17'd0, ch_max_reg};
            REG_INVERT:    prdata = {31'd0, invert_reg};
            default:       prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // input handshake: take a beat whenever the output register frees up
    // ------------------------------------------------------------------
    assign s_tready = !m_valid_reg || m_tready;
    assign in_acc   = s_tvalid && s_tready;
    assign is_tick  = in_acc && (s_tuser == FUNC_TICK);

    // ------------------------------------------------------------------
    // channel write: clamp, min checked first so it wins when min > max
    // ------------------------------------------------------------------
    always_comb begin
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  val;
        idx = s_tdata[IDX_W-1:0];
        val = s_tdata[IDX_W +: CH_W];
        priority if (val < {1'b0, ch_min_reg}) begin
            wr_val = {1'b0, ch_min_reg};
        end else if (val > {1'b0, ch_max_reg}) begin
            wr_val = {1'b0, ch_max_reg};
        end else begin
            wr_val = val;
        end
        wr_en   = in_acc && (s_tuser == FUNC_WRITE) && ({1'b0, idx} < IDX_LIM);
        wr_addr = CH_AW'(idx);
    end

    // ram is read every cycle at the pointer the next beat will see;
    // a write to that entry in the same cycle is forwarded around the ram
    assign rd_addr = ptr_next[CH_AW-1:0];

    rcppm_ram #(
        .WIDTH (CH_W),
        .DEPTH (NUM_CH)
    ) u_ch_ram (
        .clk   (aclk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_val),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            fwd_hit_reg  <= wr_en && (wr_addr == rd_addr);
        end
    end

    always_ff @(posedge aclk) begin
        fwd_data_reg <= wr_val;
    end

    // current channel time; never-written entries read as the default
    always_comb begin
        priority if (fwd_hit_reg) begin
            cur_ch = fwd_data_reg;
        end else if (rd_valid_reg) begin
            cur_ch = ram_rdata;
        end else begin
            cur_ch = CH_RESET;
        end
    end

    // ------------------------------------------------------------------
    // tick counter and phase change
    // ------------------------------------------------------------------
    always_comb begin
        logic [CH_W-1:0] gap_diff;
        logic [CH_W-1:0] gap_ticks;
        logic [CH_W:0]   acc_ch_sum;
        logic [CH_W-1:0] acc_ch_sat;
        logic [CH_W:0]   acc_sync_sum;
        logic [CH_W-1:0] acc_sync_sat;
        logic [CH_W-1:0] pad_diff;
        logic [CH_W-1:0] pad_ticks;

        // channel gap: (channel - sync) us in ticks, floored at zero
        gap_diff  = cur_ch - {1'b0, sync_reg};
        gap_ticks = (cur_ch > {1'b0, sync_reg}) ? {gap_diff[CH_W-2:0], 1'b0} : '0;

        acc_ch_sum = {1'b0, acc_reg} + {1'b0, cur_ch};
        acc_ch_sat = acc_ch_sum[CH_W] ? '1 : acc_ch_sum[CH_W-1:0];

        // frame pad: (frame - (acc + sync)) us in ticks, floored at zero
        acc_sync_sum = {1'b0, acc_reg} + {2'b0, sync_reg};
        acc_sync_sat = acc_sync_sum[CH_W] ? '1 : acc_sync_sum[CH_W-1:0];
        pad_diff     = {1'b0, frame_len_reg} - acc_sync_sat;
        pad_ticks    = ({1'b0, frame_len_reg} > acc_sync_sat) ?
                       {pad_diff[CH_W-2:0], 1'b0} : '0;

        goes_low_next = goes_low_reg;
        ptr_next      = ptr_reg;
        acc_next      = acc_reg;
        compare_next  = compare_reg;
        tick_cnt_next = tick_cnt_reg;
        pin_next      = pin_reg;
        fs_next       = 1'b0;

        if (is_tick) begin
            if (tick_cnt_reg == compare_reg) begin
                tick_cnt_next = '0;
                goes_low_next = !goes_low_reg;
                if (goes_low_reg) begin
                    pin_next = 1'b0;
                    if (ptr_reg >= PTR_LAST) begin
                        // end of frame: pad phase
                        ptr_next     = '0;
                        compare_next = pad_ticks;
                        acc_next     = '0;
                        fs_next      = 1'b1;
                    end else begin
                        compare_next = gap_ticks;
                        acc_next     = acc_ch_sat;
                        ptr_next     = ptr_reg + 1'b1;
                    end
                end else begin
                    // sync pulse
                    pin_next     = 1'b1;
                    compare_next = {sync_reg, 1'b0};
                end
            end else begin
                tick_cnt_next = tick_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            goes_low_reg <= 1'b1;
            ptr_reg      <= '0;
            acc_reg      <= '0;
            compare_reg  <= COMPARE_RST;
            tick_cnt_reg <= '0;
            pin_reg      <= 1'b0;
        end else begin
            goes_low_reg <= goes_low_next;
            ptr_reg      <= ptr_next;
            acc_reg      <= acc_next;
            compare_reg  <= compare_next;
            tick_cnt_reg <= tick_cnt_next;
            pin_reg      <= pin_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_acc) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            ppm_reg <= pin_next ^ invert_reg;
            fs_reg  <= fs_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, ppm_reg};
    assign m_tuser  = fs_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`include "assert_macros.svh"

    `ASSERT_AT(a_ptr_range, ptr_reg <= PTR_LAST, "channel pointer past channel count")
    `ASSERT_AT(a_cnt_bound, tick_cnt_reg <= compare_reg, "tick counter passed compare value")
    `ASSERT_AT(a_wr_no_fs, (in_acc && s_tuser == FUNC_WRITE) |=> !fs_reg,
               "frame start flagged on a channel write")
    `ASSERT_ALWAYS(a_rst_empty, !aresetn |=> !m_valid_reg, "output valid right after reset")

endmodule

// ----- tb/tb_rc_ppm_pulse_train_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rc_ppm_pulse_train_generator_core
// self-checking testbench of the rc ppm pulse train generator core; a
// beat-level tracker of the ppm phase machine predicts level and frame start
// of every beat, while random stalls on both streams and several register
// settings (limits crossed, zero pad, saturated frame sum) exercise the core
// ----------------------------------------------------------------------------
module tb_rc_ppm_pulse_train_generator_core;
    import rcppm_pkg::*;

    localparam int CYCLE_LIMIT = 1500000;
    localparam int IDLE_PCT    = 37;
    localparam int HOLD_CYCLES = 250;

    // tracks the ppm phase machine and holds the levels still due on m_*
    class ppm_train_tracker;
        typedef struct packed {
            logic level;
            logic frame_start;
        } ppm_beat_t;

        logic [TIME_W-1:0] frame_len_us, sync_us, ch_min_us, ch_max_us;
        logic              invert;
        logic [CH_W-1:0]   ch_time [NUM_CH];
        logic              goes_low;
        logic [PTR_W-1:0]  chan_ptr;
        logic [15:0]       frame_acc, cmp_ticks, tick_cnt;
        logic              pin_raw;
        ppm_beat_t         due_levels [$];
        int                mismatches, checked, frame_starts;

        function new();
            frame_len_us = FRAME_LEN_RST;
            sync_us      = SYNC_RST;
            ch_min_us    = CH_MIN_RST;
            ch_max_us    = CH_MAX_RST;
            invert       = 1'b0;
            foreach (ch_time[i]) ch_time[i] = CH_RESET;
            goes_low     = 1'b1;
            chan_ptr     = '0;
            frame_acc    = '0;
            cmp_ticks    = COMPARE_RST;
            tick_cnt     = '0;
            pin_raw      = 1'b0;
            mismatches   = 0;
            checked      = 0;
            frame_starts = 0;
        endfunction

        function void write_reg(reg_idx_t r, logic [31:0] v);
            case (r)
                REG_FRAME_LEN: frame_len_us = v[TIME_W-1:0];
                REG_SYNC:      sync_us      = v[TIME_W-1:0];
                REG_CH_MIN:    ch_min_us    = v[TIME_W-1:0];
                REG_CH_MAX:    ch_max_us    = v[TIME_W-1:0];
                REG_INVERT:    invert       = v[0];
                default: ;
            endcase
        endfunction

        // (a - b) microseconds as half-microsecond ticks, floored at zero
        function logic [15:0] span_ticks(int unsigned a, int unsigned b);
            if (a <= b) return 16'd0;
            return 16'((a - b) * 2);
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= 10) $display("%0t: MISMATCH %s", $realtime, msg);
        endfunction

        function void take_beat(func_t f, logic [IDX_W-1:0] idx, logic [CH_W-1:0] val);
            ppm_beat_t   beat;
            logic [CH_W-1:0] v;
            int unsigned sum;
            beat.frame_start = 1'b0;
            if (f == FUNC_WRITE) begin
                if (idx < NUM_CH) begin
                    v = val;
                    if (v < ch_min_us) v = ch_min_us;
                    else if (v > ch_max_us) v = ch_max_us;
                    ch_time[idx] = v;
                end
            end else if (tick_cnt == cmp_ticks) begin
                tick_cnt = '0;
                if (goes_low) begin
                    pin_raw = 1'b0;
                    if (chan_ptr >= NUM_CH) begin
                        // pad fills the frame, sum of channels and last sync
                        chan_ptr  = '0;
                        sum       = frame_acc + sync_us;
                        if (sum > 65535) sum = 65535;
                        cmp_ticks = span_ticks(frame_len_us, sum);
                        frame_acc = '0;
                        beat.frame_start = 1'b1;
                    end else begin
                        sum       = frame_acc + ch_time[chan_ptr];
                        cmp_ticks = span_ticks(ch_time[chan_ptr], sync_us);
                        frame_acc = (sum > 65535) ? 16'hFFFF : sum[15:0];
                        chan_ptr++;
                    end
                end else begin
                    pin_raw   = 1'b1;
                    cmp_ticks = 16'(sync_us * 2);
                end
                goes_low = ~goes_low;
            end else begin
                tick_cnt++;
            end
            beat.level = pin_raw ^ invert;
            due_levels.push_back(beat);
        endfunction

        function void check_beat(logic level, logic fs);
            ppm_beat_t want;
            if (due_levels.size() == 0) begin
                flag($sformatf("result beat with nothing due: level %0b frame_start %0b",
                               level, fs));
                return;
            end
            want = due_levels.pop_front();
            checked++;
            if (fs === 1'b1) frame_starts++;
            if (level !== want.level)
                flag($sformatf("beat %0d ppm_level expected %0b got %0b",
                               checked, want.level, level));
            if (fs !== want.frame_start)
                flag($sformatf("beat %0d frame_start expected %0b got %0b",
                               checked, want.frame_start, fs));
        endfunction
    endclass

    typedef struct {
        int unsigned frame_us;
        int unsigned sync_us;
        int unsigned min_us;
        int unsigned max_us;
        bit          inv;
        int          beats;
        bit          wide;    // allow full-range channel values
    } phase_t;

    logic        aclk;
    logic        aresetn;
    logic        psel, penable, pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;    // [3:0] channel_index, [19:4] channel_value_us
    func_t       s_tuser;    // [0] func
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;    // [0] ppm_level
    logic        m_tuser;    // [0] frame_start

    ppm_train_tracker sb = new();

    // shared between stimulus and receiver
    bit steady_run = 1'b0;   // no idling on either side
    int hold_req   = 0;      // bumped by stimulus to ask for a long receiver stall
    int hold_ack   = 0;
    int hold_left  = 0;

    int cycles     = 0;
    int beats_sent = 0;
    int reg_writes = 0;
    int settings   = 0;

    rc_ppm_pulse_train_generator_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d beats still due",
                     cycles, sb.due_levels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result side: random back-pressure, or a long hold-off when asked
    always @(negedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (steady_run) begin
            m_tready <= 1'b1;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // every accepted result beat is checked against the oldest one due
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_beat(m_tdata[0], m_tuser);
    end

    // offer one beat on s_*, with random idle cycles ahead of it; returns at
    // the accepting edge
    task automatic send_beat(func_t f, logic [IDX_W-1:0] idx, logic [CH_W-1:0] val);
        @(negedge aclk);
        while (!steady_run && $urandom_range(0, 99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {4'b0, val, idx};
        do @(posedge aclk); while (!s_tready);
        sb.take_beat(f, idx, val);
        beats_sent++;
    endtask

    // mostly ticks with random don't-care fields, the rest channel writes,
    // a quarter of those to any index including the unused ones
    task automatic random_beats(int n, bit wide, bit with_hold);
        logic [IDX_W-1:0] idx;
        logic [CH_W-1:0]  val;
        for (int i = 0; i < n; i++) begin
            if (with_hold && i == 40) hold_req++;
            if ($urandom_range(0, 9) < 7) begin
                send_beat(FUNC_TICK, 4'($urandom), 16'($urandom));
            end else begin
                idx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                  : 4'($urandom_range(0, NUM_CH - 1));
                val = (wide && $urandom_range(0, 2) == 0) ? 16'($urandom)
                                                          : 16'($urandom_range(0, 40));
                send_beat(FUNC_WRITE, idx, val);
            end
        end
    endtask

    // stop offering and wait for every due result beat
    task automatic settle_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (sb.due_levels.size() != 0) @(posedge aclk);
    endtask

    // apb setup then access; register takes the value at the access edge
    task automatic apb_write(reg_idx_t r, logic [31:0] v);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {r, 2'b00};
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_reg(r, v);
        reg_writes++;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // all five registers, with junk above each field to check masking
    task automatic apply_setting(phase_t p);
        apb_write(REG_FRAME_LEN, ({$urandom} & 32'hFFFF_8000) | p.frame_us);
        apb_write(REG_SYNC,      ({$urandom} & 32'hFFFF_8000) | p.sync_us);
        apb_write(REG_CH_MIN,    ({$urandom} & 32'hFFFF_8000) | p.min_us);
        apb_write(REG_CH_MAX,    ({$urandom} & 32'hFFFF_8000) | p.max_us);
        apb_write(REG_INVERT,    ({$urandom} & 32'hFFFF_FFFE) | p.inv);
        settings++;
    endtask

    initial begin
        phase_t plan [5];
        phase_t top_end, tail;
        logic [TIME_W-1:0] want_sync;

        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = FUNC_TICK;
        m_tready = 1'b0;

        // short frames so that many phases and frames pass by
        plan[0] = '{60,  2, 3,  9,     0, 300, 1'b1};
        // zero frame and zero sync: pad and sync pulse one tick, inverted
        plan[1] = '{0,   0, 0,  32767, 1, 200, 1'b0};
        // minimum above maximum, frame shorter than the channels
        plan[2] = '{30,  1, 12, 5,     0, 200, 1'b1};
        // positive pad; the long receiver hold-off happens here
        plan[3] = '{200, 3, 4,  12,    1, 200, 1'b1};
        // sync longer than short channels: gap floors at zero
        plan[4] = '{90,  8, 2,  14,    0, 200, 1'b1};
        top_end = '{32767, 32767, 32767, 32767, 1, 0, 1'b0};
        tail    = '{32767, 1, 0, 10, 0, 0, 1'b1};

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: clamp edges and ignored indexes under reset limits
        send_beat(FUNC_WRITE, 4'd0,  16'd0);
        send_beat(FUNC_WRITE, 4'd7,  16'hFFFF);
        send_beat(FUNC_WRITE, 4'd8,  16'd1234);
        send_beat(FUNC_WRITE, 4'd15, 16'hFFFF);
        send_beat(FUNC_WRITE, 4'd1,  16'd1000);
        send_beat(FUNC_WRITE, 4'd2,  16'd2000);
        send_beat(FUNC_WRITE, 4'd3,  16'd999);
        send_beat(FUNC_WRITE, 4'd4,  16'd2001);
        send_beat(FUNC_WRITE, 4'd5,  16'h5AA5);
        send_beat(FUNC_WRITE, 4'd6,  16'd1500);
        // ticks carry don't-care index and value
        send_beat(FUNC_TICK,  4'd15, 16'hFFFF);
        send_beat(FUNC_TICK,  4'd0,  16'd0);
        send_beat(FUNC_TICK,  4'hA,  16'h5555);
        send_beat(FUNC_TICK,  4'h5,  16'hAAAA);
        send_beat(FUNC_WRITE, 4'd9,  16'd0);
        send_beat(FUNC_TICK,  4'd0,  16'd0);
        settle_results();

        foreach (plan[k]) begin
            apply_setting(plan[k]);
            random_beats(plan[k].beats, plan[k].wide, k == 3);
            settle_results();
        end

        // line up on the start of a frame pad
        do send_beat(FUNC_TICK, 4'($urandom), 16'($urandom));
        while (!(sb.chan_ptr == 0 && !sb.goes_low));
        settle_results();

        // all-maximum channels: three of them overflow the frame sum; sync
        // flips between zero ahead of a sync pulse and maximum ahead of a
        // gap, so that every phase lasts a single tick
        steady_run = 1'b1;
        apply_setting(top_end);
        for (int c = 0; c < 3; c++) send_beat(FUNC_WRITE, 4'(c), 16'($urandom));
        do begin
            want_sync = sb.goes_low ? TIME_W'(32767) : '0;
            if (sb.sync_us != want_sync) begin
                settle_results();
                apb_write(REG_SYNC, 32'(want_sync));
            end
            send_beat(FUNC_TICK, 4'($urandom), 16'($urandom));
        end while (sb.chan_ptr != 3);
        settle_results();

        // rest of the frame short, so its pad shows the saturated sum;
        // the stretch with no idling at all runs on through the random beats
        apply_setting(tail);
        for (int c = 3; c < NUM_CH; c++)
            send_beat(FUNC_WRITE, 4'(c), 16'($urandom_range(0, 12)));
        do send_beat(FUNC_TICK, 4'($urandom), 16'($urandom));
        while (!(sb.chan_ptr == 0 && !sb.goes_low));
        random_beats(100, 1'b1, 1'b0);
        steady_run = 1'b0;

        settle_results();
        repeat (20) @(posedge aclk);
        if (sb.due_levels.size() != 0)
            sb.flag($sformatf("%0d result beats never arrived", sb.due_levels.size()));

        $display("run covered %0d input beats, %0d result beats checked, %0d frame starts",
                 beats_sent, sb.checked, sb.frame_starts);
        $display("%0d register writes over %0d settings, %0d mismatches",
                 reg_writes, settings, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
